[src/rtcc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcc_pkg: shared types and constants for the RTC calendar counter
// Word layouts, counter limits, month lengths and weekday helper tables.
// ----------------------------------------------------------------------------
package rtcc_pkg;

	localparam logic [6:0] SEC_LIMIT   = 7'h3C;
	localparam logic [6:0] MIN_LIMIT   = 7'h3C;
	localparam logic [5:0] HOUR_LIMIT  = 6'h18;
	localparam logic [4:0] MONTH_LIMIT = 5'h0D;

	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_SET  = 1'b1;

	typedef struct packed {
		logic        req_type;
		logic [31:0] time_word;
	} rtcc_in_t;

	typedef struct packed {
		logic [5:0] out_year;
		logic [3:0] out_month;
		logic [4:0] out_day;
		logic [4:0] out_hour;
		logic [5:0] out_minute;
		logic [5:0] out_second;
		logic [2:0] out_weekday;
	} rtcc_out_t;

	// days in month; months outside 1..12 count 31
	function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
		logic [4:0] d;
		d = 5'd31;
		case (month)
			4'd2:                       d = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:    d = 5'd30;
			default:                    d = 5'd31;
		endcase
		return d;
	endfunction

	// floor(26 * (m + 1) / 10) for m in 0..15
	function automatic logic [5:0] zeller_month_term(input logic [3:0] m);
		logic [5:0] t;
		t = 6'd0;
		case (m)
			4'd0:    t = 6'd2;
			4'd1:    t = 6'd5;
			4'd2:    t = 6'd7;
			4'd3:    t = 6'd10;
			4'd4:    t = 6'd13;
			4'd5:    t = 6'd15;
			4'd6:    t = 6'd18;
			4'd7:    t = 6'd20;
			4'd8:    t = 6'd23;
			4'd9:    t = 6'd26;
			4'd10:   t = 6'd28;
			4'd11:   t = 6'd31;
			4'd12:   t = 6'd33;
			4'd13:   t = 6'd36;
			4'd14:   t = 6'd39;
			default: t = 6'd41;
		endcase
		return t;
	endfunction

	// weekday 1..7 (Monday..Sunday) for year 2000+yr
	function automatic logic [2:0] weekday(input logic [5:0] yr, input logic [3:0] mon,
		input logic [4:0] day);
		logic       shift;
		logic [3:0] m;
		logic [6:0] y;
		logic       c_adj;
		logic [7:0] w;
		logic [4:0] f1;
		logic [3:0] f2;
		logic [2:0] r;
		shift = (mon == 4'd1) || (mon == 4'd2);
		m     = shift ? mon + 4'd12 : mon;
		c_adj = 1'b0;
		y     = {1'b0, yr};
		if (shift) begin
			if (yr == 6'd0) begin
				y     = 7'd99;
				c_adj = 1'b1;
			end else begin
				y = {1'b0, yr - 6'd1};
			end
		end
		// century 20 contributes 0 mod 7, century 19 contributes 1; -1 taken as +6
		w  = {1'b0, y} + {3'b0, y[6:2]} + {7'b0, c_adj} + {2'b0, zeller_month_term(m)}
			+ {3'b0, day} + 8'd6;
		f1 = {3'b0, w[7:6]} + {2'b0, w[5:3]} + {2'b0, w[2:0]};
		f2 = {2'b0, f1[4:3]} + {1'b0, f1[2:0]};
		r  = (f2 >= 4'd7) ? 3'(f2 - 4'd7) : f2[2:0];
		return (r == 3'd0) ? 3'd7 : r;
	endfunction

endpackage

[src/rtc_calendar_counter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_calendar_counter: calendar clock with weekday
// Ticks advance the time by one second with carries up to the year; set
// words load the whole date and time, but an all-zero set word changes
// nothing. Each word returns the new date, time and weekday.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | in_data  (rtcc_in_t)
//  out     | output    | out_valid / out_ready| out_data (rtcc_out_t)
//
//  From acceptance to result: an input register, then the carry chain and
//  weekday logic into the calendar registers, which are the result.
//  One word per cycle sustained while the output is not stalled. A stalled output holds both stages.
//  Reset loads 2021-03-01 09:30:00, Monday; no clearing pass.
// ----------------------------------------------------------------------------
module rtc_calendar_counter
	import rtcc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  rtcc_in_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output rtcc_out_t out_data
);

	logic       valid_s1;
	rtcc_in_t   data_s1;
	logic       adv;

	logic [5:0] year_q;
	logic [3:0] month_q;
	logic [4:0] day_q;
	logic [4:0] hour_q;
	logic [5:0] minute_q;
	logic [5:0] second_q;
	logic [2:0] weekday_q;
	logic       out_valid_q;

	logic [5:0] year_n;
	logic [3:0] month_n;
	logic [4:0] day_n;
	logic [4:0] hour_n;
	logic [5:0] minute_n;
	logic [5:0] second_n;
	logic       load;

	logic [6:0] sec_inc;
	logic [6:0] min_inc;
	logic [5:0] hour_inc;
	logic [5:0] day_inc;
	logic [4:0] month_inc;
	logic [4:0] limit;

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= in_data;
		end
	end

	always_comb begin
		sec_inc   = {1'b0, second_q} + 7'd1;
		min_inc   = {1'b0, minute_q} + 7'd1;
		hour_inc  = {1'b0, hour_q} + 6'd1;
		day_inc   = {1'b0, day_q} + 6'd1;
		month_inc = {1'b0, month_q} + 5'd1;
		limit     = month_days(month_q, year_q[1:0] == 2'b00);

		year_n   = year_q;
		month_n  = month_q;
		day_n    = day_q;
		hour_n   = hour_q;
		minute_n = minute_q;
		second_n = second_q;
		load     = 1'b1;

		if (data_s1.req_type == REQ_TICK) begin
			if (sec_inc < SEC_LIMIT) begin
				second_n = sec_inc[5:0];
			end else begin
				second_n = 6'd0;
				if (min_inc < MIN_LIMIT) begin
					minute_n = min_inc[5:0];
				end else begin
					minute_n = 6'd0;
					if (hour_inc < HOUR_LIMIT) begin
						hour_n = hour_inc[4:0];
					end else begin
						hour_n = 5'd0;
						if (day_inc <= {1'b0, limit}) begin
							day_n = day_inc[4:0];
						end else begin
							day_n = 5'd1;
							if (month_inc < MONTH_LIMIT) begin
								month_n = month_inc[3:0];
							end else begin
								month_n = 4'd1;
								year_n  = year_q + 6'd1;
							end
						end
					end
				end
			end
		end else if (data_s1.time_word != 32'd0) begin
			year_n   = data_s1.time_word[31:26];
			month_n  = data_s1.time_word[25:22];
			day_n    = data_s1.time_word[21:17];
			hour_n   = data_s1.time_word[16:12];
			minute_n = data_s1.time_word[11:6];
			second_n = data_s1.time_word[5:0];
		end else begin
			load = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_q      <= 6'd21;
			month_q     <= 4'd3;
			day_q       <= 5'd1;
			hour_q      <= 5'd9;
			minute_q    <= 6'd30;
			second_q    <= 6'd0;
			weekday_q   <= 3'd1;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
			if (valid_s1 && load) begin
				year_q    <= year_n;
				month_q   <= month_n;
				day_q     <= day_n;
				hour_q    <= hour_n;
				minute_q  <= minute_n;
				second_q  <= second_n;
				weekday_q <= weekday(year_n, month_n, day_n);
			end
		end
	end

	assign out_valid           = out_valid_q;
	assign out_data.out_year    = year_q;
	assign out_data.out_month   = month_q;
	assign out_data.out_day     = day_q;
	assign out_data.out_hour    = hour_q;
	assign out_data.out_minute  = minute_q;
	assign out_data.out_second  = second_q;
	assign out_data.out_weekday = weekday_q;

endmodule
